// ----- rtl/gbe_pkg.sv -----
// Shared constants and types of the glyph bitmap expander.
`default_nettype none
package gbe_pkg;

    // Defaults for the top level parameters
    localparam int MAX_GLYPH_DIM_DEF = 64;
    localparam int COORD_BITS_DEF    = 9;

    // One glyph byte carries this many pixels, leftmost at the MSB
    localparam int       BYTE_PIXELS = 8;
    localparam int       PIX_IDX_W   = $clog2(BYTE_PIXELS);
    localparam bit [7:0] MSB_PIXEL   = 8'h80;

    // Reset size of the latched glyph
    localparam bit [6:0] RST_WIDTH  = 7'd8;
    localparam bit [6:0] RST_HEIGHT = 7'd1;

    // Per-byte control handed from the position walker to the emitter
    typedef struct packed {
        logic [BYTE_PIXELS-1:0] emit_mask;  // pixels that produce a write
        logic [BYTE_PIXELS-1:0] bits;       // glyph bits, one = foreground
        logic                   done;       // final byte of the glyph
    } t_byte_job;

endpackage
`default_nettype wire

// ----- rtl/gbe_if.sv -----
// Valid/ready channel interfaces for glyph bytes in and pixel writes out.
`default_nettype none
interface gbe_glyph_if #(
    parameter int COORD_BITS = 9
);
    logic                  valid;
    logic                  ready;
    logic [7:0]            glyph_byte;
    logic                  first_byte;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [6:0]            glyph_width;
    logic [6:0]            glyph_height;
    logic [15:0]           fore_color;
    logic [15:0]           back_color;
    logic                  transparent_bg;

    modport source (
        output valid, glyph_byte, first_byte, origin_x, origin_y, glyph_width,
               glyph_height, fore_color, back_color, transparent_bg,
        input  ready
    );
    modport sink (
        input  valid, glyph_byte, first_byte, origin_x, origin_y, glyph_width,
               glyph_height, fore_color, back_color, transparent_bg,
        output ready
    );
endinterface

interface gbe_pixel_if #(
    parameter int COORD_BITS = 9
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [15:0]           pixel_color;
    logic                  last_of_byte;
    logic                  glyph_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_of_byte, glyph_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_of_byte, glyph_done,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/gbe_walk.sv -----
// Glyph state latch and row/column walker: places each accepted byte on screen.
`default_nettype none
module gbe_walk #(
    parameter int MAX_GLYPH_DIM = gbe_pkg::MAX_GLYPH_DIM_DEF,
    parameter int COORD_BITS    = gbe_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [7:0]            i_glyph_byte,
    input  wire logic                  i_first_byte,
    input  wire logic [COORD_BITS-1:0] i_origin_x,
    input  wire logic [COORD_BITS-1:0] i_origin_y,
    input  wire logic [6:0]            i_glyph_width,
    input  wire logic [6:0]            i_glyph_height,
    input  wire logic [15:0]           i_fore_color,
    input  wire logic [15:0]           i_back_color,
    input  wire logic                  i_transparent_bg,
    output gbe_pkg::t_byte_job         o_job,
    output logic      [COORD_BITS-1:0] o_x0,
    output logic      [COORD_BITS-1:0] o_y,
    output logic      [15:0]           o_fg,
    output logic      [15:0]           o_bg
);
    import gbe_pkg::*;

    // Offset/size width: holds the largest size plus one byte of pixels
    localparam int DIM_W = ($clog2(MAX_GLYPH_DIM + 1) > 7) ?
                           $clog2(MAX_GLYPH_DIM + 1) : 7;
    localparam int EW    = DIM_W + 1;
    localparam int LIM_W = MAX_GLYPH_DIM - (MAX_GLYPH_DIM % BYTE_PIXELS);
    localparam int LIM_H = MAX_GLYPH_DIM;

    logic [COORD_BITS-1:0] r_base_x, r_base_y;
    logic [6:0]            r_width, r_height;
    logic [15:0]           r_fg, r_bg;
    logic                  r_trans;
    logic [EW-1:0]         r_col, r_row;

    logic [COORD_BITS-1:0] s_bx, s_by;
    logic [6:0]            s_w_in, s_h_in;
    logic [15:0]           s_fg, s_bg;
    logic                  s_trans;
    logic [EW-1:0]         s_w, s_h, s_col, s_row, s_col8, s_row1;
    logic [EW-1:0]         n_col, n_row;

    // Pick the new glyph's fields on a first byte, else the latched ones
    always_comb begin
        s_bx    = i_first_byte ? i_origin_x       : r_base_x;
        s_by    = i_first_byte ? i_origin_y       : r_base_y;
        s_w_in  = i_first_byte ? i_glyph_width    : r_width;
        s_h_in  = i_first_byte ? i_glyph_height   : r_height;
        s_fg    = i_first_byte ? i_fore_color     : r_fg;
        s_bg    = i_first_byte ? i_back_color     : r_bg;
        s_trans = i_first_byte ? i_transparent_bg : r_trans;
    end

    // Clamp size: width rounded down to whole bytes, both saturated
    always_comb begin
        s_w = EW'({s_w_in[6:3], 3'b000});
        if (s_w > EW'(LIM_W)) s_w = EW'(LIM_W);
        if (s_w < EW'(BYTE_PIXELS)) s_w = EW'(BYTE_PIXELS);
        s_h = EW'(s_h_in);
        if (s_h > EW'(LIM_H)) s_h = EW'(LIM_H);
        if (s_h == '0) s_h = EW'(1);
    end

    // Current position, restarted on a new glyph or when out of range
    always_comb begin
        s_col = i_first_byte ? '0 : r_col;
        s_row = i_first_byte ? '0 : r_row;
        if (s_col >= s_w) s_col = '0;
        if (s_row >= s_h) s_row = '0;
        s_col8 = s_col + EW'(BYTE_PIXELS);
        s_row1 = s_row + EW'(1);
    end

    // Advance one byte, wrap to the next row and back to the top
    always_comb begin
        n_col = s_col8;
        n_row = s_row;
        if (s_col8 >= s_w) begin
            n_col = '0;
            n_row = (s_row1 >= s_h) ? '0 : s_row1;
        end
    end

    // Byte job for the emitter
    always_comb begin
        o_job.emit_mask = s_trans ? i_glyph_byte : '1;
        o_job.bits      = i_glyph_byte;
        o_job.done      = (s_col8 >= s_w) && (s_row1 >= s_h);
        o_x0            = s_bx + COORD_BITS'(s_col);
        o_y             = s_by + COORD_BITS'(s_row);
        o_fg            = s_fg;
        o_bg            = s_bg;
    end

    // Hold glyph state, update on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_fg     <= '0;
            r_bg     <= '0;
            r_trans  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_accept) begin
            r_base_x <= s_bx;
            r_base_y <= s_by;
            r_width  <= s_w_in;
            r_height <= s_h_in;
            r_fg     <= s_fg;
            r_bg     <= s_bg;
            r_trans  <= s_trans;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/glyph_bitmap_expander.sv -----
// Top level: glyph byte stream in, one pixel write per word out.
//
//   channel   dir  word
//   i_glyph   in   glyph byte, first-byte flag, origin, size, colors, mode
//   o_pixel   out  pixel x/y, color, last-of-byte, glyph-done
//
// A byte is placed on screen in the cycle it is accepted and held in a byte
// register; the emitter then sends one pixel per cycle through the output
// register while it is not stalled; a byte produces 0..8 pixels (eight in
// opaque mode). The next byte is taken in the cycle the last pixel leaves the
// byte register, and at once when a byte gives no pixel. A stalled output
// holds the byte register. Reset is synchronous and needs no clearing pass.
`default_nettype none
module glyph_bitmap_expander #(
    parameter int MAX_GLYPH_DIM = gbe_pkg::MAX_GLYPH_DIM_DEF,
    parameter int COORD_BITS    = gbe_pkg::COORD_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gbe_glyph_if.sink   i_glyph,
    gbe_pixel_if.source o_pixel
);
    import gbe_pkg::*;

    t_byte_job             s_job;
    logic [COORD_BITS-1:0] s_x0, s_y;
    logic [15:0]           s_fg, s_bg;
    logic                  s_accept;

    logic [BYTE_PIXELS-1:0] r_mask, r_bits;
    logic [COORD_BITS-1:0]  r_x0, r_y;
    logic [15:0]            r_fg, r_bg;
    logic                   r_done;

    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_px, r_py;
    logic [15:0]            r_color;
    logic                   r_last, r_gdone;

    logic [PIX_IDX_W-1:0]   s_idx;
    logic [BYTE_PIXELS-1:0] s_sel, s_rest;
    logic                   s_found, s_fire, s_last;

    gbe_walk #(
        .MAX_GLYPH_DIM (MAX_GLYPH_DIM),
        .COORD_BITS    (COORD_BITS)
    ) u_walk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (s_accept),
        .i_glyph_byte     (i_glyph.glyph_byte),
        .i_first_byte     (i_glyph.first_byte),
        .i_origin_x       (i_glyph.origin_x),
        .i_origin_y       (i_glyph.origin_y),
        .i_glyph_width    (i_glyph.glyph_width),
        .i_glyph_height   (i_glyph.glyph_height),
        .i_fore_color     (i_glyph.fore_color),
        .i_back_color     (i_glyph.back_color),
        .i_transparent_bg (i_glyph.transparent_bg),
        .o_job            (s_job),
        .o_x0             (s_x0),
        .o_y              (s_y),
        .o_fg             (s_fg),
        .o_bg             (s_bg)
    );

    // Find the leftmost pixel still to emit
    always_comb begin
        s_idx   = '0;
        s_found = 1'b0;
        for (int i = 0; i < BYTE_PIXELS; i++) begin
            if (!s_found && r_mask[BYTE_PIXELS-1-i]) begin
                s_idx   = PIX_IDX_W'(i);
                s_found = 1'b1;
            end
        end
        s_sel  = MSB_PIXEL >> s_idx;
        s_rest = r_mask & ~s_sel;
        s_last = (s_rest == '0);
    end

    // Emit when a pixel waits and the output register is free or draining
    assign s_fire   = s_found && (!r_out_valid || o_pixel.ready);
    assign i_glyph.ready = !s_found || (s_fire && s_last);
    assign s_accept = i_glyph.valid && i_glyph.ready;

    // Byte register: load on accept, drop emitted pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (s_accept) begin
            r_mask <= s_job.emit_mask;
        end else if (s_fire) begin
            r_mask <= s_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_bits <= s_job.bits;
            r_done <= s_job.done;
            r_x0   <= s_x0;
            r_y    <= s_y;
            r_fg   <= s_fg;
            r_bg   <= s_bg;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_px    <= r_x0 + COORD_BITS'(s_idx);
            r_py    <= r_y;
            r_color <= ((r_bits & s_sel) != '0) ? r_fg : r_bg;
            r_last  <= s_last;
            r_gdone <= r_done;
        end
    end

    assign o_pixel.valid        = r_out_valid;
    assign o_pixel.pixel_x      = r_px;
    assign o_pixel.pixel_y      = r_py;
    assign o_pixel.pixel_color  = r_color;
    assign o_pixel.last_of_byte = r_last;
    assign o_pixel.glyph_done   = r_gdone;

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the glyph bitmap expander: directed glyph bytes, then random glyphs.
module testbench;

    import gbe_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int MAX_DIM      = MAX_GLYPH_DIM_DEF;
    localparam int TOTAL_ITEMS  = 270;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 32;
    localparam int TIMEOUT_NS   = 2_000_000;

    // One glyph byte word as it is offered to the block
    typedef struct packed {
        logic [7:0]    gbyte;
        logic          first;
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [6:0]    w;
        logic [6:0]    h;
        logic [15:0]   fg;
        logic [15:0]   bg;
        logic          tr;
    } glyph_item_t;

    // One pixel write word
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [15:0]   color;
        logic          last;
        logic          done;
    } pixel_t;

    // Directed step: the byte, and where chk is set, the pixel count and the first pixel
    typedef struct packed {
        glyph_item_t   item;
        logic          chk;
        logic [3:0]    n;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [15:0]   ecol;
        logic          edone;
    } step_row_t;

    typedef enum {
        GLYPH_WHOLE,
        GLYPH_CUT,
        GLYPH_OVERRUN,
        GLYPH_ODD_SIZE,
        GLYPH_NO_HEAD
    } glyph_shape_e;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gbe_glyph_if #(.COORD_BITS(CW)) glyph_ch ();
    gbe_pixel_if #(.COORD_BITS(CW)) pixel_ch ();

    glyph_bitmap_expander dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_glyph (glyph_ch),
        .o_pixel (pixel_ch)
    );

    // Latched glyph as the block should hold it
    logic [CW-1:0] glyph_x     = '0;
    logic [CW-1:0] glyph_y     = '0;
    logic [6:0]    glyph_w     = RST_WIDTH;
    logic [6:0]    glyph_h     = RST_HEIGHT;
    logic [15:0]   glyph_fg    = '0;
    logic [15:0]   glyph_bg    = '0;
    logic          glyph_trans = 1'b0;
    int            col_off     = 0;
    int            row_off     = 0;

    pixel_t pending_pixels[$];
    int     error_count     = 0;
    int     source_idle_pct = 0;
    int     sink_idle_pct   = 0;
    bit     hold_request    = 1'b0;
    int     hold_left       = 0;

    localparam int DIRECTED_STEPS = 21;
    step_row_t directed_steps [DIRECTED_STEPS] = '{
        // reset glyph: 8x1 at the origin, black on black, opaque
        '{'{8'hA5, 0, 9'h1FF, 9'h0AA, 64, 64, 16'hFFFF, 16'hFFFF, 1},
          1, 8, 0, 0, 16'h0000, 1},
        // 16x2 glyph at the bottom right corner: coordinates wrap
        '{'{8'hFF, 1, 511, 511, 16, 2, 16'hFFFF, 16'h0000, 0}, 1, 8, 511, 511, 16'hFFFF, 0},
        '{'{8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF, 1}, 1, 8, 7, 511, 16'h0000, 0},
        '{'{8'h80, 0, 9'h1FF, 9'h1FF, 127, 127, 16'hFFFF, 16'hFFFF, 1},
          1, 8, 511, 0, 16'hFFFF, 0},
        '{'{8'h01, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 8, 7, 0, 16'h0000, 1},
        // byte past the final one restarts the same glyph
        '{'{8'h3C, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 8, 511, 511, 16'h0000, 0},
        // transparent zero byte gives no pixel
        '{'{8'h00, 1, 100, 200, 8, 1, 16'hF800, 16'h07E0, 1}, 1, 0, 0, 0, 16'h0000, 0},
        '{'{8'h81, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 2, 100, 200, 16'hF800, 1},
        // largest glyph
        '{'{8'h55, 1, 0, 0, 64, 64, 16'h1234, 16'hABCD, 0}, 1, 8, 0, 0, 16'hABCD, 0},
        '{'{8'hAA, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 8, 8, 0, 16'h1234, 0},
        // width below eight and height zero
        '{'{8'hF0, 1, 3, 5, 7, 0, 16'h5A5A, 16'hA5A5, 0}, 1, 8, 3, 5, 16'h5A5A, 1},
        // oversize glyph saturates
        '{'{8'h01, 1, 256, 256, 127, 127, 16'hFFFF, 16'h0000, 1}, 1, 1, 263, 256, 16'hFFFF, 0},
        // width not a multiple of eight
        '{'{8'h7F, 1, 500, 510, 13, 3, 16'h0001, 16'hFFFE, 0}, 1, 8, 500, 510, 16'hFFFE, 0},
        '{'{8'hFF, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 8, 500, 511, 16'h0001, 0},
        // new glyph before the old one is complete
        '{'{8'hC3, 1, 10, 20, 8, 2, 16'hAAAA, 16'h5555, 0}, 1, 8, 10, 20, 16'hAAAA, 0},
        '{'{8'h3C, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 8, 10, 21, 16'h5555, 1},
        // transparent final byte of zeros, then a restart
        '{'{8'hFF, 1, 0, 0, 16, 1, 16'h7777, 16'h8888, 1}, 1, 8, 0, 0, 16'h7777, 0},
        '{'{8'h00, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 0, 0, 0, 16'h0000, 0},
        '{'{8'h08, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 0}, 1, 1, 4, 0, 16'h7777, 0},
        '{'{8'h96, 1, 9'h155, 9'h0AA, 40, 2, 16'hC0DE, 16'h3E1F, 0}, 0, 0, 0, 0, 16'h0000, 0},
        '{'{8'h69, 0, 9'h0AA, 9'h155, 85, 42, 16'h3F21, 16'hC0DE, 1}, 0, 0, 0, 0, 16'h0000, 0}
    };

    // Clock
    always #2 i_clk = ~i_clk;

    // Flag one field that differs
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Expand one accepted glyph byte into the pixel writes it should cause
    function automatic int expand_glyph_byte(input glyph_item_t it);
        int     w;
        int     h;
        int     n;
        logic   one;
        logic   done;
        bit     have;
        pixel_t held;
        pixel_t p;
        if (it.first) begin
            glyph_x     = it.ox;
            glyph_y     = it.oy;
            glyph_w     = it.w;
            glyph_h     = it.h;
            glyph_fg    = it.fg;
            glyph_bg    = it.bg;
            glyph_trans = it.tr;
            col_off     = 0;
            row_off     = 0;
        end
        // effective size: width in whole bytes, both clamped to the glyph limit
        w = int'(glyph_w) & ~7;
        if (w > (MAX_DIM & ~7)) w = MAX_DIM & ~7;
        if (w < BYTE_PIXELS) w = BYTE_PIXELS;
        h = int'(glyph_h);
        if (h > MAX_DIM) h = MAX_DIM;
        if (h < 1) h = 1;
        if (col_off >= w) col_off = 0;
        if (row_off >= h) row_off = 0;
        done = (col_off + BYTE_PIXELS >= w) && (row_off + 1 >= h);
        n    = 0;
        have = 1'b0;
        for (int i = 0; i < BYTE_PIXELS; i++) begin
            one = |(it.gbyte & (MSB_PIXEL >> i));
            if (one || !glyph_trans) begin
                p.x     = CW'(int'(glyph_x) + col_off + i);
                p.y     = CW'(int'(glyph_y) + row_off);
                p.color = one ? glyph_fg : glyph_bg;
                p.last  = 1'b0;
                p.done  = done;
                if (have) pending_pixels.push_back(held);
                held = p;
                have = 1'b1;
                n++;
            end
        end
        if (have) begin
            held.last = 1'b1;
            pending_pixels.push_back(held);
        end
        // advance column, then row, wrapping to the top left corner
        col_off += BYTE_PIXELS;
        if (col_off >= w) begin
            col_off = 0;
            row_off++;
            if (row_off >= h) row_off = 0;
        end
        return n;
    endfunction

    // Offer one glyph byte word and predict its pixels once accepted
    task automatic send_byte(input glyph_item_t it, output int n);
        @(negedge i_clk);
        while ($urandom_range(99) < source_idle_pct) begin
            glyph_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        glyph_ch.glyph_byte     = it.gbyte;
        glyph_ch.first_byte     = it.first;
        glyph_ch.origin_x       = it.ox;
        glyph_ch.origin_y       = it.oy;
        glyph_ch.glyph_width    = it.w;
        glyph_ch.glyph_height   = it.h;
        glyph_ch.fore_color     = it.fg;
        glyph_ch.back_color     = it.bg;
        glyph_ch.transparent_bg = it.tr;
        glyph_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!glyph_ch.ready) @(posedge i_clk);
        n = expand_glyph_byte(it);
    endtask

    // Drop valid and hold until every predicted pixel has come out
    task automatic wait_drained();
        @(negedge i_clk);
        glyph_ch.valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // Switch idle rates between phases; the last phase opens with a long output stall
    task automatic enter_phase(input int ph);
        wait_drained();
        source_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 47 : 0;
        sink_idle_pct   = (ph == 0) ? 47 : (ph == 1) ? 27 : 0;
        if (ph == 2) hold_request = 1'b1;
    endtask

    // Receiver: random stalls, or a long hold when asked
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            pixel_ch.ready = 1'b0;
            hold_left--;
        end else begin
            pixel_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each pixel word with the oldest prediction
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && pixel_ch.valid && pixel_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel word at x %0d, y %0d", pixel_ch.pixel_x,
                       pixel_ch.pixel_y);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.x, pixel_ch.pixel_x);
                check_field("pixel_y", want.y, pixel_ch.pixel_y);
                check_field("pixel_color", want.color, pixel_ch.pixel_color);
                check_field("last_of_byte", want.last, pixel_ch.last_of_byte);
                check_field("glyph_done", want.done, pixel_ch.glyph_done);
            end
        end
    end

    // Stimulus
    initial begin
        glyph_item_t  it;
        pixel_t       lead;
        glyph_shape_e shape;
        int           n;
        int           sent;
        int           cur_phase;
        int           ph;
        int           glyph_idx;
        int           nbytes;
        int           full;
        int           gw;
        int           gh;
        int           gtr;
        int           r;

        glyph_ch.valid          = 1'b0;
        glyph_ch.glyph_byte     = '0;
        glyph_ch.first_byte     = 1'b0;
        glyph_ch.origin_x       = '0;
        glyph_ch.origin_y       = '0;
        glyph_ch.glyph_width    = '0;
        glyph_ch.glyph_height   = '0;
        glyph_ch.fore_color     = '0;
        glyph_ch.back_color     = '0;
        glyph_ch.transparent_bg = 1'b0;
        pixel_ch.ready          = 1'b0;

        // hold reset, release it between edges
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        source_idle_pct = 27;
        sink_idle_pct   = 47;
        cur_phase       = 0;
        sent            = 0;

        // directed steps
        for (int k = 0; k < DIRECTED_STEPS; k++) begin
            send_byte(directed_steps[k].item, n);
            if (directed_steps[k].chk) begin
                check_field("pixel count", directed_steps[k].n, n);
                if (n > 0 && n == int'(directed_steps[k].n)) begin
                    lead = pending_pixels[pending_pixels.size() - n];
                    check_field("first pixel_x", directed_steps[k].ex, lead.x);
                    check_field("first pixel_y", directed_steps[k].ey, lead.y);
                    check_field("first pixel_color", directed_steps[k].ecol, lead.color);
                    check_field("first glyph_done", directed_steps[k].edone, lead.done);
                end
            end
            sent++;
        end

        // random glyphs, mostly whole and small
        glyph_idx = 0;
        while (sent < TOTAL_ITEMS) begin
            ph = (sent < 90) ? 0 : (sent < 180) ? 1 : 2;
            if (ph != cur_phase) begin
                enter_phase(ph);
                cur_phase = ph;
            end

            r = $urandom_range(19);
            shape = (r < 2) ? GLYPH_CUT : (r == 2) ? GLYPH_OVERRUN :
                    (r < 5) ? GLYPH_ODD_SIZE : (r == 5) ? GLYPH_NO_HEAD : GLYPH_WHOLE;

            r = $urandom_range(24);
            if (r == 0) begin
                gw = 64;
                gh = $urandom_range(1, 2);
            end else if (r == 1) begin
                gw = 8;
                gh = $urandom_range(20, 64);
            end else begin
                gw = 8 * $urandom_range(1, 3);
                gh = $urandom_range(1, 5);
            end
            full   = (gw / 8) * gh;
            nbytes = full;
            case (shape)
                GLYPH_CUT: begin
                    nbytes = (full > 1) ? $urandom_range(1, full - 1) : 1;
                end
                GLYPH_OVERRUN: begin
                    nbytes = full + $urandom_range(1, 8);
                end
                GLYPH_ODD_SIZE: begin
                    gw     = $urandom_range(0, 127);
                    gh     = $urandom_range(0, 127);
                    nbytes = $urandom_range(1, 12);
                end
                GLYPH_NO_HEAD: begin
                    nbytes = $urandom_range(1, 6);
                end
                default: ;
            endcase
            gtr = $urandom_range(1);

            for (int i = 0; i < nbytes && sent < TOTAL_ITEMS; i++) begin
                // fields of non-first bytes carry junk that must be ignored
                it.ox = CW'($urandom_range(0, 511));
                it.oy = CW'($urandom_range(0, 511));
                it.w  = 7'($urandom_range(0, 127));
                it.h  = 7'($urandom_range(0, 127));
                it.fg = 16'($urandom_range(0, 65535));
                it.bg = 16'($urandom_range(0, 65535));
                it.tr = 1'($urandom_range(1));
                it.first = (i == 0) && (shape != GLYPH_NO_HEAD);
                if (it.first) begin
                    it.w  = 7'(gw);
                    it.h  = 7'(gh);
                    it.tr = 1'(gtr);
                end
                r = $urandom_range(7);
                it.gbyte = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                send_byte(it, n);
                sent++;
            end

            // long output stall early on, while the sender keeps offering
            if (glyph_idx == 3) hold_request = 1'b1;
            glyph_idx++;
        end

        // drain with both sides free
        @(negedge i_clk);
        glyph_ch.valid  = 1'b0;
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gbe_pkg.sv
rtl/gbe_if.sv
rtl/gbe_walk.sv
rtl/glyph_bitmap_expander.sv
verif/testbench.sv
